/* design/sfrc_pkg.sv */
// Shared types and constants for the speed frame receiver with checksum.
// Used by sfrc_collect and speed_frame_receiver_checksum_core; depends on nothing.
package sfrc_pkg;

  // Frame layout: header at 0..1, speed bytes at 2..17, checksum at 18, tail at 19.
  localparam int unsigned SPEED_COUNT = 4;
  localparam int unsigned BUF_LEN     = 17;
  localparam logic [4:0]  DATA_START  = 5'd2;
  localparam logic [4:0]  CHECK_POS   = 5'd18;
  localparam logic [4:0]  TAIL_POS    = 5'd19;

  // Configuration register reset values.
  localparam logic [7:0] HEADER_FIRST_RST  = 8'hCC;
  localparam logic [7:0] HEADER_SECOND_RST = 8'hDD;
  localparam logic [7:0] TAIL_VALUE_RST    = 8'hEE;

  // Configuration register indexes (byte address / 4).
  typedef enum logic [1:0] {
    REG_HEADER_FIRST  = 2'd0,
    REG_HEADER_SECOND = 2'd1,
    REG_TAIL_VALUE    = 2'd2
  } sfrc_reg_t;

  // Frame judgment codes.
  typedef enum logic [1:0] {
    STAT_OK   = 2'd0,
    STAT_CSUM = 2'd1,
    STAT_TAIL = 2'd2
  } sfrc_status_t;

  typedef struct packed {
    logic [7:0] header_first;
    logic [7:0] header_second;
    logic [7:0] tail_value;
  } sfrc_cfg_t;

  typedef struct packed {
    logic         valid;
    logic [31:0]  speed_four;
    logic [31:0]  speed_three;
    logic [31:0]  speed_two;
    logic [31:0]  speed_one;
    sfrc_status_t status;
  } sfrc_result_t;

endpackage

/* design/sfrc_collect.sv */
// Frame tracker: header hunt, byte collection, checksum and tail judgment, held speeds.
// Depends on sfrc_pkg.
module sfrc_collect
  import sfrc_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         step,
  input  logic [7:0]   rx_byte,
  input  sfrc_cfg_t    cfg,
  output sfrc_result_t res
);

  logic [7:0]  previous_byte;
  logic        in_frame;
  logic [4:0]  byte_position;
  logic [7:0]  running_sum;
  logic [7:0]  collect_buffer [BUF_LEN];
  logic [31:0] held_speeds [SPEED_COUNT];

  logic        in_frame_next;
  logic [4:0]  byte_position_next;
  logic [7:0]  running_sum_next;
  logic        buf_write;
  logic [4:0]  buf_index;
  logic        frame_ok;
  logic [31:0] frame_words [SPEED_COUNT];

  // Assemble the little-endian speed words from the collected bytes.
  always_comb begin
    for (int k = 0; k < SPEED_COUNT; k++) begin
      frame_words[k] = {collect_buffer[4*k+3], collect_buffer[4*k+2],
                        collect_buffer[4*k+1], collect_buffer[4*k]};
    end
  end

  // Next frame state for the byte at the input register.
  always_comb begin
    in_frame_next      = in_frame;
    byte_position_next = byte_position;
    running_sum_next   = running_sum;
    buf_write          = 1'b0;
    buf_index          = byte_position - DATA_START;
    res                = '0;
    res.status         = STAT_OK;
    frame_ok           = 1'b0;
    if (!in_frame) begin
      if (previous_byte == cfg.header_first && rx_byte == cfg.header_second) begin
        in_frame_next      = 1'b1;
        byte_position_next = DATA_START;
        running_sum_next   = previous_byte + rx_byte;
      end
    end else if (byte_position < CHECK_POS) begin
      buf_write          = 1'b1;
      running_sum_next   = running_sum + rx_byte;
      byte_position_next = byte_position + 5'd1;
    end else if (byte_position == CHECK_POS) begin
      buf_write          = 1'b1;
      byte_position_next = TAIL_POS;
    end else begin
      // Tail is checked before the checksum.
      res.valid = 1'b1;
      if (rx_byte != cfg.tail_value) begin
        res.status = STAT_TAIL;
      end else if (running_sum != collect_buffer[BUF_LEN-1]) begin
        res.status = STAT_CSUM;
      end else begin
        res.status = STAT_OK;
        frame_ok   = 1'b1;
      end
      in_frame_next      = 1'b0;
      byte_position_next = '0;
      running_sum_next   = '0;
    end
    res.speed_one   = frame_ok ? frame_words[0] : held_speeds[0];
    res.speed_two   = frame_ok ? frame_words[1] : held_speeds[1];
    res.speed_three = frame_ok ? frame_words[2] : held_speeds[2];
    res.speed_four  = frame_ok ? frame_words[3] : held_speeds[3];
  end

  // Control state and held speeds.
  always_ff @(posedge clk) begin
    if (rst) begin
      previous_byte <= '0;
      in_frame      <= 1'b0;
      byte_position <= '0;
      running_sum   <= '0;
      for (int k = 0; k < SPEED_COUNT; k++) begin
        held_speeds[k] <= '0;
      end
    end else if (step) begin
      previous_byte <= rx_byte;
      in_frame      <= in_frame_next;
      byte_position <= byte_position_next;
      running_sum   <= running_sum_next;
      if (frame_ok) begin
        for (int k = 0; k < SPEED_COUNT; k++) begin
          held_speeds[k] <= frame_words[k];
        end
      end
    end
  end

  // Collected bytes; every entry is written by a frame before it is judged.
  always_ff @(posedge clk) begin
    if (step && buf_write) begin
      collect_buffer[buf_index] <= rx_byte;
    end
  end

  // A result only comes from the tail position of a running frame.
  a_result_at_tail: assert property (@(posedge clk) disable iff (rst)
    res.valid |-> (in_frame && byte_position == TAIL_POS))
    else $error("result outside the tail position");

  // A judged frame always returns the tracker to hunting.
  a_hunt_after_result: assert property (@(posedge clk) disable iff (rst)
    (step && res.valid) |=> (!in_frame && byte_position == 5'd0))
    else $error("tracker did not return to hunting after a frame");

  // Held speeds change only on a good frame.
  a_speeds_hold: assert property (@(posedge clk) disable iff (rst)
    !(step && res.valid && res.status == STAT_OK) |=>
      ($stable(held_speeds[0]) && $stable(held_speeds[1]) &&
       $stable(held_speeds[2]) && $stable(held_speeds[3])))
    else $error("held speeds changed without a good frame");

endmodule

/* design/speed_frame_receiver_checksum_core.sv */
// Top level of the speed frame receiver: APB registers, input register, output register.
// Depends on sfrc_pkg and sfrc_collect.
//
//  channel  | direction | contents
//  ---------+-----------+------------------------------------------------------------
//  s_axis   | in        | tdata[7:0] rx_byte
//  m_axis   | out       | tdata: speed_one..speed_four, frame_status, zero padding
//  apb      | in/out    | header_first @0x0, header_second @0x4, tail_value @0x8
//
// One byte is accepted every cycle unless a stalled result and a waiting byte fill both
// registers; a frame's tail byte passes the input register, then its result the output register.
// The rate is set by the frame update, which is combinational between the two registers.
// Reset is synchronous and returns to header hunting with zero held speeds.
// A stalled result holds in the output register; one more byte may enter behind it.
module speed_frame_receiver_checksum_core
  import sfrc_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  // Input stream
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,   // [7:0] rx_byte
  // Output stream
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [135:0] m_axis_tdata,   // [31:0] speed_one, [63:32] speed_two,
                                       // [95:64] speed_three, [127:96] speed_four,
                                       // [129:128] frame_status, [135:130] zero
  // Configuration port
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [3:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  sfrc_cfg_t    cfg;
  sfrc_result_t res;
  logic         in_valid;
  logic [7:0]   in_byte;
  logic         out_valid;
  logic [135:0] out_data;
  logic         advance;
  sfrc_reg_t    reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = sfrc_reg_t'(paddr[3:2]);

  // Register writes; addresses beyond the list are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.header_first  <= HEADER_FIRST_RST;
      cfg.header_second <= HEADER_SECOND_RST;
      cfg.tail_value    <= TAIL_VALUE_RST;
    end else if (psel && penable && pwrite && pready) begin
      unique case (reg_sel)
        REG_HEADER_FIRST:  cfg.header_first  <= pwdata[7:0];
        REG_HEADER_SECOND: cfg.header_second <= pwdata[7:0];
        REG_TAIL_VALUE:    cfg.tail_value    <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    unique case (reg_sel)
      REG_HEADER_FIRST:  prdata = {24'd0, cfg.header_first};
      REG_HEADER_SECOND: prdata = {24'd0, cfg.header_second};
      REG_TAIL_VALUE:    prdata = {24'd0, cfg.tail_value};
      default:           prdata = '0;
    endcase
  end

  // The byte in the input register is processed whenever the output slot can take a result.
  assign advance       = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || !out_valid || m_axis_tready;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte <= s_axis_tdata;
    end
  end

  sfrc_collect u_collect (
    .clk     (clk),
    .rst     (rst),
    .step    (advance),
    .rx_byte (in_byte),
    .cfg     (cfg),
    .res     (res)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && res.valid) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res.valid) begin
      out_data <= {6'd0, res.status, res.speed_four, res.speed_three,
                   res.speed_two, res.speed_one};
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;

endmodule

/* verif/testbench.sv */
// Self-checking testbench for speed_frame_receiver_checksum_core.
// Depends on sfrc_pkg and the core RTL; a scoreboard class tracks the frame parser and
// checks every result transaction against the frame judgment it expects.
module testbench;
  import sfrc_pkg::*;

  localparam int unsigned IDLE_LIMIT   = 1000;
  localparam int unsigned RANDOM_BYTES = 700;
  localparam int unsigned PHASES       = 6;
  localparam int unsigned SETTLE       = 6;
  localparam logic [3:0]  UNMAPPED_ADDR = 4'hC;

  typedef enum {READY_ALWAYS, READY_RANDOM, READY_LONG_STALLS} stall_mode_t;

  // Speed words after a frame, plus the judgment of that frame.
  typedef struct packed {
    logic [3:0][31:0] speeds;
    sfrc_status_t     status;
  } frame_report_t;

  // Tracks header hunting, collection and judgment, and holds the reports still owed.
  class frame_scoreboard;
    logic [7:0]       header_first;
    logic [7:0]       header_second;
    logic [7:0]       tail_value;
    logic [7:0]       last_byte;
    bit               framing;
    logic [4:0]       position;
    logic [7:0]       sum;
    logic [7:0]       payload [BUF_LEN];
    logic [3:0][31:0] held;
    frame_report_t    awaited [$];
    int unsigned      failures;

    function new();
      header_first  = HEADER_FIRST_RST;
      header_second = HEADER_SECOND_RST;
      tail_value    = TAIL_VALUE_RST;
      last_byte     = '0;
      framing       = 0;
      position      = '0;
      sum           = '0;
      held          = '0;
      failures      = 0;
      foreach (payload[i]) payload[i] = '0;
    endfunction

    // Only the low byte of a write matters; unmapped addresses are ignored.
    function void note_config(logic [3:0] addr, logic [31:0] data);
      case (addr[3:2])
        REG_HEADER_FIRST:  header_first  = data[7:0];
        REG_HEADER_SECOND: header_second = data[7:0];
        REG_TAIL_VALUE:    tail_value    = data[7:0];
        default: ;
      endcase
    endfunction

    function void take_byte(logic [7:0] b);
      frame_report_t report;
      if (!framing) begin
        if (last_byte == header_first && b == header_second) begin
          framing  = 1;
          position = DATA_START;
          sum      = last_byte + b;
        end
      end else if (position < CHECK_POS) begin
        payload[position - DATA_START] = b;
        sum      = sum + b;
        position = position + 5'd1;
      end else if (position == CHECK_POS) begin
        payload[BUF_LEN - 1] = b;
        position = TAIL_POS;
      end else begin
        // The tail is judged before the checksum; speeds latch only on a good frame.
        if (b != tail_value) begin
          report.status = STAT_TAIL;
        end else if (sum != payload[BUF_LEN - 1]) begin
          report.status = STAT_CSUM;
        end else begin
          for (int k = 0; k < SPEED_COUNT; k++) begin
            held[k] = {payload[4*k+3], payload[4*k+2], payload[4*k+1], payload[4*k]};
          end
          report.status = STAT_OK;
        end
        report.speeds = held;
        awaited.push_back(report);
        framing  = 0;
        position = '0;
        sum      = '0;
      end
      last_byte = b;
    endfunction

    function void match_frame_result(logic [135:0] data);
      frame_report_t want;
      string names [4];
      names = '{"speed_one", "speed_two", "speed_three", "speed_four"};
      if (awaited.size() == 0) begin
        $error("result transaction with no frame outstanding: tdata %h", data);
        failures++;
        return;
      end
      want = awaited.pop_front();
      for (int k = 0; k < SPEED_COUNT; k++) begin
        if (data[32*k +: 32] !== want.speeds[k]) begin
          $error("%s: expected %h, actual %h", names[k], want.speeds[k], data[32*k +: 32]);
          failures++;
        end
      end
      if (data[129:128] !== want.status) begin
        $error("frame_status: expected %0d, actual %0d", want.status, data[129:128]);
        failures++;
      end
    endfunction

    function int unsigned outstanding();
      return awaited.size();
    endfunction
  endclass

  logic         clk;
  logic         rst;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [7:0]   s_axis_tdata;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [135:0] m_axis_tdata;
  logic         psel;
  logic         penable;
  logic         pwrite;
  logic [3:0]   paddr;
  logic [31:0]  pwdata;
  logic [31:0]  prdata;
  logic         pready;

  frame_scoreboard sb;
  int unsigned     burst_left;
  int unsigned     bytes_sent;

  speed_frame_receiver_checksum_core uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Sends one byte; a new burst starts with a random gap of idle cycles.
  task automatic send_byte(logic [7:0] b);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = $urandom_range(0, 5);
      repeat (gap) begin
        @(negedge clk);
        s_axis_tvalid = 0;
      end
    end
    @(negedge clk);
    s_axis_tvalid = 1;
    s_axis_tdata  = b;
    do @(posedge clk); while (!s_axis_tready);
    sb.take_byte(b);
    burst_left--;
    bytes_sent++;
  endtask

  // APB write: setup cycle, then access cycle.
  task automatic write_reg(logic [3:0] addr, logic [7:0] value);
    @(negedge clk);
    psel    = 1;
    penable = 0;
    pwrite  = 1;
    paddr   = addr;
    pwdata  = ($urandom() & 32'hFFFF_FF00) | {24'd0, value};
    @(negedge clk);
    penable = 1;
    do @(posedge clk); while (!pready);
    sb.note_config(addr, pwdata);
    @(negedge clk);
    psel    = 0;
    penable = 0;
    pwrite  = 0;
  endtask

  // Stops the sender and waits until every owed result has arrived and the pipe is empty.
  task automatic drain();
    @(negedge clk);
    s_axis_tvalid = 0;
    burst_left = 0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Biased toward the configured marker bytes and the extremes.
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 7))
      0: return sb.tail_value;
      1: return sb.header_first;
      2: return sb.header_second;
      3: return 8'h00;
      4: return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Sends a whole frame; with chain set, a previous byte equal to header_first opens it.
  task automatic send_frame(logic [15:0][7:0] body, bit bad_sum, bit bad_tail, bit chain);
    logic [7:0] check;
    logic [7:0] flip;
    check = sb.header_first + sb.header_second;
    for (int i = 0; i < 16; i++) check = check + body[i];
    flip = 8'($urandom_range(1, 255));
    if (bad_sum) check = check ^ flip;
    if (!(chain && !sb.framing && sb.last_byte == sb.header_first)) send_byte(sb.header_first);
    send_byte(sb.header_second);
    for (int i = 0; i < 16; i++) send_byte(body[i]);
    send_byte(check);
    flip = 8'($urandom_range(1, 255));
    send_byte(bad_tail ? (sb.tail_value ^ flip) : sb.tail_value);
  endtask

  // Mostly whole frames with random content, some with a bad checksum or tail; some noise and cut-off frames.
  task automatic run_phase(int unsigned budget);
    int unsigned start;
    int unsigned pick;
    int unsigned n;
    logic [15:0][7:0] body;
    start = bytes_sent;
    while (bytes_sent - start < budget) begin
      for (int i = 0; i < 16; i++) body[i] = pick_byte();
      pick = $urandom_range(0, 19);
      if (pick < 15) begin
        send_frame(body, (pick == 9 || pick == 10 || pick >= 13), (pick >= 11),
                   1'($urandom_range(0, 1)));
      end else if (pick < 18) begin
        n = $urandom_range(1, 4);
        repeat (n) send_byte(pick_byte());
      end else begin
        send_byte(sb.header_first);
        send_byte(sb.header_second);
        n = $urandom_range(0, 15);
        for (int i = 0; i < n; i++) send_byte(body[i]);
      end
    end
  endtask

  // Result side backpressure: always ready, random, or long stalls.
  initial begin : result_backpressure
    stall_mode_t mode;
    int unsigned mode_left;
    int unsigned hold_left;
    m_axis_tready = 0;
    mode = READY_ALWAYS;
    mode_left = 0;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (mode_left == 0) begin
        mode = stall_mode_t'($urandom_range(0, 2));
        mode_left = $urandom_range(20, 80);
      end
      mode_left--;
      case (mode)
        READY_ALWAYS: m_axis_tready = 1;
        READY_RANDOM: m_axis_tready = ($urandom_range(0, 9) < 7);
        default: begin
          if (hold_left == 0) begin
            m_axis_tready = !m_axis_tready;
            hold_left = m_axis_tready ? $urandom_range(1, 4) : $urandom_range(1, 15);
          end
          hold_left--;
        end
      endcase
    end
  end

  // Check every result transaction.
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) sb.match_frame_result(m_axis_tdata);
  end

  // Ends the run if neither stream moves for too long.
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < IDLE_LIMIT) begin
      @(posedge clk);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    logic [15:0][7:0] body;
    logic [7:0] hf;
    logic [7:0] hs;
    logic [7:0] tl;
    sb = new();
    rst = 1;
    s_axis_tvalid = 0;
    s_axis_tdata  = '0;
    psel    = 0;
    penable = 0;
    pwrite  = 0;
    paddr   = '0;
    pwdata  = '0;
    burst_left = 0;
    bytes_sent = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // Reset settings: a false start, a repeated header_first, then one good frame whose
    // data holds all-ones, all-zeros, tail-valued and header-valued bytes.
    send_byte(HEADER_FIRST_RST);
    send_byte(8'h00);
    send_byte(HEADER_FIRST_RST);
    body = {32'h7856_3412, 32'hEEDD_CCEE, 32'h0000_0000, 32'hFFFF_FFFF};
    send_frame(body, 0, 0, 1);

    // Random phases, each under its own register settings.
    for (int phase = 0; phase < PHASES; phase++) begin
      drain();
      case (phase)
        0: begin
          hf = 8'h00; hs = 8'hFF; tl = 8'h00;
        end
        1: begin
          hf = 8'hFF; hs = 8'h00; tl = 8'hFF;
        end
        2: begin
          hf = 8'($urandom_range(0, 255)); hs = hf; tl = 8'($urandom_range(0, 255));
        end
        3: begin
          hf = 8'($urandom_range(0, 255)); hs = 8'($urandom_range(0, 255));
          tl = 8'($urandom_range(0, 255));
        end
        4: begin
          hf = 8'($urandom_range(0, 255)); hs = 8'($urandom_range(0, 255)); tl = hf;
        end
        default: begin
          hf = HEADER_FIRST_RST; hs = HEADER_SECOND_RST; tl = TAIL_VALUE_RST;
        end
      endcase
      write_reg({REG_HEADER_FIRST, 2'b00}, hf);
      write_reg({REG_HEADER_SECOND, 2'b00}, hs);
      write_reg({REG_TAIL_VALUE, 2'b00}, tl);
      if (phase == 2 || phase == 4) write_reg(UNMAPPED_ADDR, 8'($urandom_range(0, 255)));
      run_phase(RANDOM_BYTES / PHASES);
    end

    drain();
    if (sb.failures == 0 && sb.outstanding() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

/* sim.f */
design/sfrc_pkg.sv
design/sfrc_collect.sv
design/speed_frame_receiver_checksum_core.sv
verif/testbench.sv
